[src/cal_pkg.sv]
package cal_pkg;

	typedef enum logic [3:0] {
		OP_INSERT  = 4'd0,
		OP_REMOVE  = 4'd1,
		OP_REPLACE = 4'd2,
		OP_CLEAR   = 4'd3,
		OP_BEGIN   = 4'd4,
		OP_END     = 4'd5,
		OP_NEXT    = 4'd6,
		OP_PRIOR   = 4'd7,
		OP_READ    = 4'd8,
		OP_FIND    = 4'd9,
		OP_MOVE    = 4'd10
	} opcode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [3:0] opcode;
		logic [7:0] data_value;
		logic [3:0] target_position;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       success;
		logic [1:0] status;
		logic [4:0] item_count_out;
		logic [3:0] cursor_out;
		logic       cursor_valid_out;
		logic       is_empty;
		logic       is_full;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_MVRD,
		S_MVCAP,
		S_SHIFT,
		S_UPSET,
		S_PUT,
		S_FIND,
		S_FETCH,
		S_RESP
	} state_t;

endpackage

[src/cursor_array_list_unit.sv]
// Cursor array list: an ordered list of byte items in a CAPACITY-entry store
// with a cursor marking one item.
// Request channel (req_valid/req_ready, payload req) carries one operation;
// response channel (rsp_valid/rsp_ready, payload rsp) returns one result per
// request, showing the list and cursor after the operation.
// One request is worked at a time; req_ready is high only while idle.
// The store is a single-port-read, single-port-write memory walked by one
// address sequencer, one entry per cycle, so the time a request takes depends
// on the operation and the number of entries that must move.
// The next request is taken in the cycle after a result is registered.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and waits before returning to idle.
// Reset empties the list and invalidates the cursor; store contents are
// left as they are and never reach a response before being written.
module cursor_array_list_unit
	import cal_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int TW = (CW > 4) ? CW : 4;

	logic [7:0] mem [CAPACITY];
	logic [7:0] rdata_q;

	state_t state_q, state_d;
	req_t   req_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] cur_q;
	logic          curv_q;
	logic          succ_q;
	logic [1:0]    stat_q;
	logic [7:0]    moved_q;
	logic [IW-1:0] rptr_q, rend_q, waddr_q;
	logic          rmore_q, pend_q, dir_up_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata;
	logic          full_c, empty_c, at_last_c, match_c, slot_free_c;
	logic [CW-1:0] last_c;
	logic [TW-1:0] tgt_ext_c, last_ext_c;
	logic [IW-1:0] tgt_clamp_c;
	opcode_t       op_c;

	assign op_c        = opcode_t'(req_q.opcode);
	assign full_c      = (count_q == CW'(CAPACITY));
	assign empty_c     = (count_q == '0);
	assign last_c      = count_q - 1'b1;
	assign at_last_c   = (CW'(cur_q) == last_c);
	assign match_c     = pend_q && (rdata_q == req_q.data_value);
	assign slot_free_c = !rsp_valid_q || rsp_ready;
	assign tgt_ext_c   = TW'(req_q.target_position);
	assign last_ext_c  = TW'(last_c);
	assign tgt_clamp_c = (tgt_ext_c > last_ext_c) ? IW'(last_c) : IW'(req_q.target_position);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_FETCH;
				if (op_c == OP_INSERT) begin
					if (!full_c) state_d = S_SHIFT;
				end else if (op_c == OP_CLEAR) begin
					state_d = S_FETCH;
				end else if (!empty_c) begin
					case (op_c)
						OP_REMOVE:  state_d = S_SHIFT;
						OP_REPLACE: state_d = S_PUT;
						OP_FIND:    state_d = S_FIND;
						OP_MOVE:    state_d = S_MVRD;
						default:    state_d = S_FETCH;
					endcase
				end
			end
			S_MVRD:  state_d = S_MVCAP;
			S_MVCAP: state_d = S_SHIFT;
			S_SHIFT: begin
				if (!rmore_q) begin
					if (op_c == OP_REMOVE)
						state_d = S_FETCH;
					else if (op_c == OP_MOVE && !dir_up_q)
						state_d = S_UPSET;
					else
						state_d = S_PUT;
				end
			end
			S_UPSET: state_d = S_SHIFT;
			S_PUT:   state_d = S_FETCH;
			S_FIND: begin
				if (match_c || !rmore_q) state_d = S_FETCH;
			end
			S_FETCH: state_d = S_RESP;
			S_RESP: begin
				if (slot_free_c) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		req_ready = (state_q == S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = req_q.data_value;
		mem_raddr = cur_q;
		case (state_q)
			S_SHIFT: begin
				mem_we    = pend_q;
				mem_waddr = waddr_q;
				mem_wdata = rdata_q;
				mem_raddr = rptr_q;
			end
			S_FIND: mem_raddr = rptr_q;
			S_PUT: begin
				mem_we = 1'b1;
				if (op_c == OP_MOVE) mem_wdata = moved_q;
			end
			default: mem_raddr = cur_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			curv_q      <= 1'b0;
			rmore_q     <= 1'b0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RESP && slot_free_c)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) req_q <= req;
				end
				S_EXEC: begin
					succ_q <= 1'b0;
					stat_q <= ST_OK;
					pend_q <= 1'b0;
					if (op_c == OP_INSERT) begin
						if (full_c) begin
							stat_q <= ST_FULL;
						end else begin
							// shift up items from the slot after the cursor
							rptr_q   <= IW'(last_c);
							rend_q   <= curv_q ? IW'(cur_q + 1'b1) : '0;
							rmore_q  <= curv_q ? !at_last_c : !empty_c;
							dir_up_q <= 1'b1;
							cur_q    <= curv_q ? IW'(cur_q + 1'b1) : '0;
							curv_q   <= 1'b1;
							count_q  <= count_q + 1'b1;
						end
					end else if (op_c == OP_CLEAR) begin
						count_q <= '0;
						cur_q   <= '0;
						curv_q  <= 1'b0;
					end else if (empty_c && op_c inside {[OP_REMOVE:OP_MOVE]}) begin
						stat_q <= ST_EMPTY;
					end else begin
						case (op_c)
							OP_REMOVE: begin
								rptr_q   <= IW'(cur_q + 1'b1);
								rend_q   <= IW'(last_c);
								rmore_q  <= !at_last_c;
								dir_up_q <= 1'b0;
								count_q  <= last_c;
								if (last_c == '0) begin
									cur_q  <= '0;
									curv_q <= 1'b0;
								end else if (at_last_c) begin
									cur_q <= '0;
								end
							end
							OP_BEGIN: cur_q <= '0;
							OP_END:   cur_q <= IW'(last_c);
							OP_NEXT: begin
								if (!at_last_c) begin
									cur_q  <= cur_q + 1'b1;
									succ_q <= 1'b1;
								end
							end
							OP_PRIOR: begin
								if (cur_q != '0) begin
									cur_q  <= cur_q - 1'b1;
									succ_q <= 1'b1;
								end
							end
							OP_FIND: begin
								rptr_q  <= cur_q;
								rend_q  <= IW'(last_c);
								rmore_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_MVCAP: begin
					// lift the cursor item out, close the gap, then reopen at target
					moved_q  <= rdata_q;
					rptr_q   <= IW'(cur_q + 1'b1);
					rend_q   <= IW'(last_c);
					rmore_q  <= !at_last_c;
					pend_q   <= 1'b0;
					dir_up_q <= 1'b0;
					cur_q    <= tgt_clamp_c;
				end
				S_UPSET: begin
					rptr_q   <= IW'(count_q - 2'd2);
					rend_q   <= cur_q;
					rmore_q  <= (last_c != CW'(cur_q));
					pend_q   <= 1'b0;
					dir_up_q <= 1'b1;
				end
				S_SHIFT: begin
					if (rmore_q) begin
						pend_q  <= 1'b1;
						waddr_q <= dir_up_q ? IW'(rptr_q + 1'b1) : IW'(rptr_q - 1'b1);
						if (rptr_q == rend_q)
							rmore_q <= 1'b0;
						else
							rptr_q <= dir_up_q ? rptr_q - 1'b1 : rptr_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				S_FIND: begin
					if (match_c) begin
						cur_q  <= waddr_q;
						succ_q <= 1'b1;
					end else if (!rmore_q) begin
						cur_q <= IW'(last_c);
					end else begin
						pend_q  <= 1'b1;
						waddr_q <= rptr_q;
						if (rptr_q == rend_q)
							rmore_q <= 1'b0;
						else
							rptr_q <= rptr_q + 1'b1;
					end
				end
				S_RESP: begin
					if (slot_free_c) begin
						rsp_q.read_data        <= curv_q ? rdata_q : 8'd0;
						rsp_q.success          <= succ_q;
						rsp_q.status           <= stat_q;
						rsp_q.item_count_out   <= 5'(count_q);
						rsp_q.cursor_out       <= 4'(cur_q);
						rsp_q.cursor_valid_out <= curv_q;
						rsp_q.is_empty         <= empty_c;
						rsp_q.is_full          <= full_c;
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[src/cal_checker.sv]
module cal_checker
	import cal_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request at a time: busy right after accepting
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_cursor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.cursor_valid_out == !rsp.is_empty) &&
			(rsp.is_empty == (rsp.item_count_out == 5'd0)))
		else $error("cursor validity disagrees with item count");

	a_no_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.cursor_valid_out |->
			rsp.read_data == 8'd0 && rsp.cursor_out == 4'd0 && !rsp.success)
		else $error("invalid cursor shows data");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.is_full && !rsp.success)
		else $error("full status without full list");

endmodule

bind cursor_array_list_unit cal_checker u_cal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
